// ----- hw/rtl/truncatable_prime_checker_assert.svh -----
// Assertion macros shared by the truncatable prime checker RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef TRUNCATABLE_PRIME_CHECKER_ASSERT_SVH
`define TRUNCATABLE_PRIME_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define TPC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");

// Next-cycle implication.
`define TPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

// ----- hw/rtl/tpc_pkg.sv -----
// Package for the truncatable prime checker: command/status structs,
// divide-by-ten constants and the prime digit test. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

  localparam int SUM_WIDTH      = 64;
  localparam int OUT_DATA_WIDTH = 72;

  // floor(x / 10) = (x * RECIP10) >> RECIP_SHIFT, exact for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic load;
    logic div;
    logic dig_fail;
    logic prime_init;
    logic rem_start;
    logic trunc_fail;
    logic d_inc;
    logic shift;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic t_nonpos;
    logic digit_good;
    logic trunc_ok;
    logic sq_over;
    logic rem_busy;
    logic rem_done;
    logic rem_zero;
    logic q_zero;
    logic out_free;
  } sts_t;

  function automatic logic digit_prime(input logic [3:0] dig);
    return (dig == 4'd2) || (dig == 4'd3) || (dig == 4'd5) || (dig == 4'd7);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/truncatable_prime_checker.sv -----
// Top level of the truncatable prime checker: controller plus datapath.
// Depends on tpc_pkg, tpc_ctrl, tpc_datapath (and tpc_rem_unit below it).
//
// Usage:
//   Input stream: one word per value. s_tdata carries the value (low
//   VALUE_WIDTH bits taken as two's complement), s_tlast marks the last
//   value of an array.
//   Output stream: one word per input word, in order. m_tdata bit 0 is
//   digits_all_prime, bit 1 truncations_prime, bits 65:2 the running sum
//   after this word, the rest zero. m_tlast echoes s_tlast; the sum
//   restarts from zero after such a word.
//   One word is worked on at a time; s_tready is high only while idle.
//   A value of zero or below goes straight to its result. For a positive
//   value, each decimal digit is tested in turn, and each truncation
//   still under test is divided by trial divisors up to its square root
//   in the bit-serial remainder unit.
//   The result waits in an output register; the next word is taken while
//   it waits, but its own result holds until m_tready frees the register.
//   Reset (rst, synchronous) clears the sum and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module truncatable_prime_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [31:0]                    s_tdata,   // value
  input  wire logic                           s_tlast,   // last_item
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // digits_all_prime, truncations_prime, running_sum[63:0], zero pad
  output logic [tpc_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
  output logic                                m_tlast    // sum_final
);

  tpc_pkg::cmd_t cmd;
  tpc_pkg::sts_t sts;

  tpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpc_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_rem_unit.sv -----
// Restoring remainder unit: dividend mod divisor, one dividend bit a cycle.
// Used by tpc_datapath for the trial divisions; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tpc_rem_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [VALUE_WIDTH-1:0]   dividend,
  input  wire logic [VALUE_WIDTH/2:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic                          rem_zero
);

  localparam int DW = VALUE_WIDTH / 2 + 1;
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [DW:0]            rem;
  logic [VALUE_WIDTH-1:0] dvd;
  logic [CW-1:0]          cnt;
  logic [DW:0]            rem_sh;
  logic [DW:0]            rem_step;

  always_comb begin
    rem_sh   = {rem[DW-1:0], dvd[VALUE_WIDTH-1]};
    rem_step = (rem_sh >= {1'b0, divisor}) ? rem_sh - {1'b0, divisor} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      cnt <= CW'(VALUE_WIDTH);
    end else if (busy) begin
      rem <= rem_step;
      dvd <= {dvd[VALUE_WIDTH-2:0], 1'b0};
      cnt <= cnt - CW'(1);
    end
  end

  assign rem_zero = (rem == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_datapath.sv -----
// Datapath of the truncatable prime checker: digit split, trial divisor
// and square, flags, accumulator and output register. Uses tpc_pkg, tpc_rem_unit.
`timescale 1ns / 1ps
`default_nettype none

module tpc_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tpc_pkg::cmd_t                      cmd,
  output tpc_pkg::sts_t                           sts,
  input  wire logic [31:0]                        s_tdata,
  input  wire logic                               s_tlast,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [tpc_pkg::OUT_DATA_WIDTH-1:0]      m_tdata,
  output logic                                    m_tlast
);

  `include "truncatable_prime_checker_assert.svh"

  localparam int W  = VALUE_WIDTH;
  localparam int DW = W / 2 + 1;
  localparam int SW = W + 2;
  localparam int PADW = tpc_pkg::OUT_DATA_WIDTH - tpc_pkg::SUM_WIDTH - 2;

  logic [W-1:0]                    val;
  logic [W-1:0]                    t;
  logic [W-1:0]                    q;
  logic [DW-1:0]                   d;
  logic [SW-1:0]                   sq;
  logic                            dig_ok;
  logic                            trunc_ok;
  logic                            last;
  logic [tpc_pkg::SUM_WIDTH-1:0]   acc;

  logic [63:0]                     prod;
  logic [63:0]                     prod_sh;
  logic [3:0]                      digit;
  logic [tpc_pkg::SUM_WIDTH-1:0]   sval;
  logic [tpc_pkg::SUM_WIDTH-1:0]   sum_after;
  logic                            rem_busy;
  logic                            rem_done;
  logic                            rem_zero;

  always_comb begin
    prod    = 64'(32'(t)) * 64'(tpc_pkg::RECIP10);
    prod_sh = prod >> tpc_pkg::RECIP_SHIFT;
    // low digit: t - 10*q taken mod 16
    digit   = t[3:0] - {q[0], 3'b000} - {q[2:0], 1'b0};
    sval    = tpc_pkg::SUM_WIDTH'(signed'(val));
    sum_after = acc + (trunc_ok ? sval : '0);
  end

  tpc_rem_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rem_start),
    .dividend (t),
    .divisor  (d),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val      <= s_tdata[W-1:0];
      t        <= s_tdata[W-1:0];
      last     <= s_tlast;
      dig_ok   <= 1'b1;
      trunc_ok <= 1'b1;
    end
    if (cmd.div) begin
      q <= prod_sh[W-1:0];
    end
    if (cmd.dig_fail) begin
      dig_ok   <= 1'b0;
      trunc_ok <= 1'b0;
    end
    if (cmd.trunc_fail) begin
      trunc_ok <= 1'b0;
    end
    if (cmd.prime_init) begin
      d  <= DW'(2);
      sq <= SW'(4);
    end else if (cmd.d_inc) begin
      // (d+1)^2 = d^2 + 2d + 1
      d  <= d + DW'(1);
      sq <= sq + SW'({d, 1'b0}) + SW'(1);
    end
    if (cmd.shift) begin
      t <= q;
    end
    if (cmd.emit) begin
      m_tdata <= {{PADW{1'b0}}, sum_after, trunc_ok, dig_ok};
      m_tlast <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        acc      <= last ? '0 : sum_after;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.t_nonpos   = val[W-1] || (val == '0);
    sts.digit_good = tpc_pkg::digit_prime(digit);
    sts.trunc_ok   = trunc_ok;
    sts.sq_over    = sq > SW'(t);
    sts.rem_busy   = rem_busy;
    sts.rem_done   = rem_done;
    sts.rem_zero   = rem_zero;
    sts.q_zero     = (q == '0);
    sts.out_free   = !m_tvalid || m_tready;
  end

  `TPC_ASSERT_IMPL(a_flag_order, clk, rst, !dig_ok, !trunc_ok)
  `TPC_ASSERT_NEXT(a_acc_clear, clk, rst, cmd.emit && last, acc == '0)

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_ctrl.sv -----
// Controller of the truncatable prime checker: sequences digit steps and
// trial divisions, issues commands to tpc_datapath. Uses tpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire tpc_pkg::sts_t sts,
  output tpc_pkg::cmd_t      cmd
);

  `include "truncatable_prime_checker_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DIG   = 3'd3;
  localparam logic [2:0] S_PCHK  = 3'd4;
  localparam logic [2:0] S_PMOD  = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = sts.t_nonpos ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_DIG;
      end
      S_DIG: begin
        // a bad digit also fails the truncation test
        if (!sts.digit_good) begin
          cmd.dig_fail = 1'b1;
          state_next   = S_FIN;
        end else if (sts.trunc_ok) begin
          cmd.prime_init = 1'b1;
          state_next     = S_PCHK;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_PCHK: begin
        if (sts.sq_over) begin
          state_next = S_NEXT;
        end else begin
          cmd.rem_start = 1'b1;
          state_next    = S_PMOD;
        end
      end
      S_PMOD: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            cmd.trunc_fail = 1'b1;
            state_next     = S_NEXT;
          end else begin
            cmd.d_inc  = 1'b1;
            state_next = S_PCHK;
          end
        end
      end
      S_NEXT: begin
        cmd.shift  = 1'b1;
        state_next = sts.q_zero ? S_FIN : S_DIV;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `TPC_ASSERT_IMPL(a_no_restart, clk, rst, cmd.rem_start, !sts.rem_busy)
  `TPC_ASSERT_NEXT(a_emit_idle, clk, rst, cmd.emit, s_tready)

endmodule

`default_nettype wire

// ----- test/prime_verdict_checker.sv -----
// Watches both streams of the truncatable prime checker, predicts each result word
// and compares it field by field. Depends on tpc_pkg for the output word width.
`timescale 1ns / 1ps

module prime_verdict_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [31:0]                        s_tdata,   // value
  input  logic                               s_tlast,   // last_item
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // digits_all_prime, truncations_prime, running_sum[63:0], zero pad
  input  logic [tpc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input  logic                               m_tlast,   // sum_final
  output int                                 mismatch_count,
  output int                                 words_outstanding
);

  typedef struct packed {
    logic        dig_ok;
    logic        trunc_ok;
    logic [63:0] sum;
    logic        closes;
  } verdict_t;

  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;

  verdict_t    expected_verdicts[$];
  logic [63:0] running_total;
  int          fail_tally;
  int          result_index;

  function automatic logic is_prime_digit(input logic [63:0] dig);
    return dig == 2 || dig == 3 || dig == 5 || dig == 7;
  endfunction

  function automatic logic trial_division_prime(input logic [63:0] n);
    logic [63:0] d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Updates the running total as the block does; clears it after a closing word.
  function automatic verdict_t predict_verdict(input logic [31:0] word, input logic last);
    verdict_t    v;
    logic [63:0] raw;
    logic [63:0] sval;
    logic [63:0] t;
    logic        neg;
    raw        = {32'b0, word} & VALUE_MASK;
    neg        = raw[VALUE_WIDTH-1];
    sval       = neg ? (raw | ~VALUE_MASK) : raw;
    v.dig_ok   = 1'b1;
    v.trunc_ok = 1'b1;
    // zero and negatives have no digits to test
    if (!neg && raw != 0) begin
      for (t = raw; t > 0 && v.dig_ok; t = t / 10) begin
        if (!is_prime_digit(t % 10)) v.dig_ok = 1'b0;
      end
      for (t = raw; t > 0 && v.trunc_ok; t = t / 10) begin
        if (!trial_division_prime(t) || !is_prime_digit(t % 10)) v.trunc_ok = 1'b0;
      end
    end
    if (v.trunc_ok) running_total = running_total + sval;
    v.sum    = running_total;
    v.closes = last;
    if (last) running_total = '0;
    return v;
  endfunction

  initial begin
    running_total     = '0;
    fail_tally        = 0;
    result_index      = 0;
    mismatch_count    = 0;
    words_outstanding = 0;
  end

  always @(posedge clk) begin : monitor
    verdict_t want;
    verdict_t got;
    if (rst) begin
      running_total = '0;
      expected_verdicts.delete();
    end else begin
      // result side first: it always belongs to an older input word
      if (m_tvalid && m_tready) begin
        got.dig_ok   = m_tdata[0];
        got.trunc_ok = m_tdata[1];
        got.sum      = m_tdata[65:2];
        got.closes   = m_tlast;
        if (expected_verdicts.size() == 0) begin
          if (fail_tally < 10)
            $display("result word %0d arrived with nothing expected: dig=%0b trunc=%0b sum=%0d last=%0b",
                     result_index, got.dig_ok, got.trunc_ok, $signed(got.sum), got.closes);
          fail_tally++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want || m_tdata[tpc_pkg::OUT_DATA_WIDTH-1:66] !== '0) begin
            if (fail_tally < 10)
              $display("result word %0d: expected dig=%0b trunc=%0b sum=%0d last=%0b, got dig=%0b trunc=%0b sum=%0d last=%0b pad=%h",
                       result_index, want.dig_ok, want.trunc_ok, $signed(want.sum), want.closes,
                       got.dig_ok, got.trunc_ok, $signed(got.sum), got.closes,
                       m_tdata[tpc_pkg::OUT_DATA_WIDTH-1:66]);
            fail_tally++;
          end
        end
        result_index++;
      end
      if (s_tvalid && s_tready)
        expected_verdicts.push_back(predict_verdict(s_tdata, s_tlast));
    end
    words_outstanding <= expected_verdicts.size();
    mismatch_count    <= fail_tally;
  end

endmodule

// ----- test/truncatable_prime_checker_tb.sv -----
// Top of the truncatable prime checker testbench: clock, reset, stimulus, stalls
// and verdict. Depends on tpc_pkg, prime_verdict_checker and the block's RTL.
`timescale 1ns / 1ps

module truncatable_prime_checker_tb;

  localparam int RANDOM_WORDS    = 77;
  // divisor budget per word keeps the run short; words whose sweep would exceed it are drawn again
  localparam int COST_CAP        = 1500;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int HOLD_OFF_AFTER  = 40;
  localparam int DRAIN_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT  = 300000;

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [31:0]                        s_tdata;   // value
  logic                               s_tlast;   // last_item
  logic                               m_tvalid;
  logic                               m_tready;
  // digits_all_prime, truncations_prime, running_sum[63:0], zero pad
  logic [tpc_pkg::OUT_DATA_WIDTH-1:0] m_tdata;
  logic                               m_tlast;   // sum_final

  int mismatch_count;
  int words_outstanding;
  int words_taken;
  int quiet_cycles;

  truncatable_prime_checker i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  prime_verdict_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .mismatch_count   (mismatch_count),
    .words_outstanding(words_outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) words_taken <= 0;
    else if (s_tvalid && s_tready) words_taken <= words_taken + 1;
  end

  // no word moving on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // trial divisors the block walks through for a word, in the order truncations are tested
  function automatic int sweep_cost(input logic [31:0] v);
    longint unsigned t;
    longint unsigned d;
    int              total;
    logic            composite;
    logic [3:0]      dig;
    total = 0;
    if (v[31] || v == 0) return 0;
    for (t = v; t > 0; t = t / 10) begin
      composite = (t < 2);
      for (d = 2; d * d <= t && !composite; d++) begin
        total++;
        if (t % d == 0) composite = 1'b1;
      end
      total++;
      dig = 4'(t % 10);
      if (composite || !(dig == 2 || dig == 3 || dig == 5 || dig == 7)) break;
    end
    return total;
  endfunction

  function automatic logic [31:0] draw_value();
    logic [31:0] v;
    int          r;
    int          n;
    do begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // built only from prime digits: these reach the primality sweep
        n = $urandom_range(1, 5);
        v = '0;
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: v = v * 10 + 2;
            1: v = v * 10 + 3;
            2: v = v * 10 + 5;
            default: v = v * 10 + 7;
          endcase
        end
      end else if (r < 65) begin
        v = $urandom;
      end else if (r < 75) begin
        v = {1'b1, 31'($urandom)};
      end else if (r < 80) begin
        v = '0;
      end else if (r < 90) begin
        v = $urandom_range(0, 999);
      end else begin
        v = $urandom_range(1, 99999);
      end
    end while (sweep_cost(v) > COST_CAP);
    return v;
  endfunction

  // entered just after the edge that took the previous word
  task automatic send_word(input logic [31:0] value, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      s_tlast  = $urandom_range(0, 1);
      repeat (gap) @(negedge clk);
    end
    s_tdata  = value;
    s_tlast  = last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin : receiver
    int stall_left;
    bit pressured;
    stall_left = 0;
    pressured  = 1'b0;
    m_tready   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!pressured && words_taken >= HOLD_OFF_AFTER) begin
        // long hold-off so the output register fills and the input stalls
        pressured = 1'b1;
        m_tready  = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        if (stall_left > 0) begin
          m_tready = 1'b0;
          stall_left--;
        end else begin
          m_tready = 1'b1;
        end
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int remaining;
    int run_len;
    int i;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: signed extremes, zero, single digits, squares, short truncatable primes
    send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFE, 1'b1);
    send_word(32'd1, 1'b0);
    send_word(32'd2, 1'b0);
    send_word(32'd3, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'd7, 1'b1);
    send_word(32'd4, 1'b0);
    send_word(32'd9, 1'b0);
    send_word(32'd25, 1'b0);
    send_word(32'd35, 1'b0);
    send_word(32'd27, 1'b0);
    send_word(32'd77, 1'b1);
    send_word(32'd23, 1'b0);
    send_word(32'd37, 1'b0);
    send_word(32'd53, 1'b0);
    send_word(32'd73, 1'b0);
    send_word(32'd373, 1'b0);
    send_word(32'd2333, 1'b0);
    send_word(32'd23333, 1'b1);
    // negative value that closes an array on its own
    send_word(32'hFFFF_FF9C, 1'b1);

    remaining = RANDOM_WORDS;
    while (remaining > 0) begin
      run_len = $urandom_range(1, 8);
      for (i = 0; i < run_len && remaining > 0; i++) begin
        send_word(draw_value(), (i == run_len - 1) || (remaining == 1));
        remaining--;
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (words_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && words_outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_rem_unit.sv
hw/rtl/tpc_datapath.sv
hw/rtl/tpc_ctrl.sv
hw/rtl/truncatable_prime_checker.sv
test/prime_verdict_checker.sv
test/truncatable_prime_checker_tb.sv
